// ===== sv/pls_pkg.sv =====
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps
package pls_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = 5;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OP_W       = 3;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_INSERT    = 3'd1,
      OP_REMOVE    = 3'd2,
      OP_READ_POS  = 3'd3,
      OP_CUR_START = 3'd4,
      OP_CUR_ADV   = 3'd5,
      OP_READ_CUR  = 3'd6
   } req_op_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic [IDX_W-1:0]      idx;
      logic [DATA_WIDTH-1:0] word;
   } chain_cmd_type;

endpackage

// ===== sv/pls_cell.sv =====
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
module pls_cell
   import pls_pkg::*;
(
   input  logic                  clock,
   input  chain_cmd_type         cmd,
   input  logic [IDX_W-1:0]      cell_idx,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (cell_idx == cmd.idx) begin
               entry_in = cmd.word;
            end else if (cell_idx > cmd.idx) begin
               entry_in = left_data;
            end
         end
         CELL_REMOVE: begin
            if (cell_idx >= cmd.idx) begin
               entry_in = right_data;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;

endmodule

// ===== sv/pls_chain.sv =====
// Row of list cells with neighbor links and the positional read select.
`timescale 1ns / 1ps
module pls_chain
   import pls_pkg::*;
(
   input  logic                  clock,
   input  chain_cmd_type         cmd,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end

      pls_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_idx   (IDX_W'(i)),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i])
      );
   end

   assign rd_data = cell_data[rd_idx];

endmodule

// ===== sv/positional_list_store.sv =====
// Top level of the positional list store: request decode, count, cursor and response word.
//
//   channel | ports           | contents
//   --------+-----------------+------------------------------------------------
//   request | req_t*          | tuser: req_type; tdata: position, entry
//   result  | rsp_t*          | tdata: ok, read_data, length, is_empty, past_end
//
// One request per cycle unless a response is held; each response is registered at accept.
// Insert and remove shift every entry behind the position in the cell row as one step.
// A held response stalls the request side until rsp_tready takes it.
// Synchronous reset clears count, cursor and the response valid; entries are not cleared.
`timescale 1ns / 1ps
module positional_list_store
   import pls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   input  logic [39:0] req_tdata,   // [4:0] position, [36:5] entry, [39:37] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] ok, [32:1] read_data, [37:33] length,
                                    // [38] is_empty, [39] past_end
);

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic                  accept;
   req_op_type            in_op;
   logic [CNT_W-1:0]      in_pos;
   logic [DATA_WIDTH-1:0] in_word;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cursor_ff, cursor_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  ok_ff, ok_in;
   logic [DATA_WIDTH-1:0] read_ff, read_in;

   chain_cmd_type         cmd;
   logic [IDX_W-1:0]      rd_idx;
   logic                  rd_en;
   logic [DATA_WIDTH-1:0] rd_data;

   assign in_op   = req_op_type'(req_tuser);
   assign in_pos  = req_tdata[4:0];
   assign in_word = req_tdata[36:5];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ok_in     = 1'b0;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      cmd.op    = CELL_HOLD;
      cmd.idx   = '0;
      cmd.word  = in_word;
      rd_idx    = '0;
      rd_en     = 1'b0;
      unique case (in_op)
         OP_APPEND: begin
            if (count_ff < DEPTH_C) begin
               ok_in    = 1'b1;
               cmd.op   = CELL_INSERT;
               cmd.idx  = count_ff[IDX_W-1:0];
               count_in = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (count_ff < DEPTH_C && in_pos >= 5'd1 && in_pos <= count_ff + 1'b1) begin
               ok_in    = 1'b1;
               cmd.op   = CELL_INSERT;
               cmd.idx  = IDX_W'(in_pos - 1'b1);
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (in_pos >= 5'd1 && in_pos <= count_ff) begin
               ok_in    = 1'b1;
               cmd.op   = CELL_REMOVE;
               cmd.idx  = IDX_W'(in_pos - 1'b1);
               count_in = count_ff - 1'b1;
            end
         end
         OP_READ_POS: begin
            rd_idx = IDX_W'(in_pos - 1'b1);
            if (in_pos >= 5'd1 && in_pos <= count_ff) begin
               ok_in = 1'b1;
               rd_en = 1'b1;
            end
         end
         OP_CUR_START: begin
            ok_in     = 1'b1;
            cursor_in = 5'd1;
         end
         OP_CUR_ADV: begin
            ok_in = 1'b1;
            if (cursor_ff < DEPTH_C + 1'b1) begin
               cursor_in = cursor_ff + 1'b1;
            end
         end
         OP_READ_CUR: begin
            rd_idx = IDX_W'(cursor_ff - 1'b1);
            if (cursor_ff >= 5'd1 && cursor_ff <= count_ff) begin
               ok_in = 1'b1;
               rd_en = 1'b1;
            end
         end
         default: ok_in = 1'b0;
      endcase
      if (!accept) begin
         cmd.op = CELL_HOLD;
      end
      read_in      = rd_en ? rd_data : '0;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   pls_chain u_chain (
      .clock   (clock),
      .cmd     (cmd),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff   <= ok_in;
         read_ff <= read_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {cursor_ff > count_ff, count_ff == '0, count_ff, read_ff, ok_ff};

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= DEPTH_C + 1'b1)
      else $error("cursor above saturation limit");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff) && $stable(cursor_ff))
      else $error("count or cursor moved without a request");

   a_read_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (ok_ff || read_ff == '0))
      else $error("read data on a failed request");
`endif

endmodule

// ===== tb/list_result_checker.sv =====
// Checker for the positional list store: predicts each response word and compares it.
`timescale 1ns / 1ps
module list_result_checker
   import pls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   input  logic [39:0] req_tdata,   // [4:0] position, [36:5] entry, [39:37] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [0] ok, [32:1] read_data, [37:33] length,
                                    // [38] is_empty, [39] past_end
   output int          mismatch_count,
   output int          pending_count,
   output int          stored_len
);

   localparam int PRINT_CAP = 60;

   typedef struct packed {
      logic                  ok;
      logic [DATA_WIDTH-1:0] read_data;
      logic [CNT_W-1:0]      length;
      logic                  is_empty;
      logic                  past_end;
   } list_result_type;

   logic [DATA_WIDTH-1:0] held [DEPTH];
   int unsigned           held_len;
   int unsigned           cursor_pos;
   list_result_type       expected_words [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic apply_request(input req_op_type op, input int unsigned pos,
                                input logic [DATA_WIDTH-1:0] w,
                                output list_result_type r);
      int i;
      r = '0;
      case (op)
         OP_APPEND: begin
            if (held_len < DEPTH) begin
               held[held_len] = w;
               held_len++;
               r.ok = 1'b1;
            end
         end
         OP_INSERT: begin
            if (held_len < DEPTH && pos >= 1 && pos <= held_len + 1) begin
               for (i = held_len; i >= int'(pos); i--)
                  held[i] = held[i-1];
               held[pos-1] = w;
               held_len++;
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (pos >= 1 && pos <= held_len) begin
               for (i = pos; i < int'(held_len); i++)
                  held[i-1] = held[i];
               held_len--;
               r.ok = 1'b1;
            end
         end
         OP_READ_POS: begin
            if (pos >= 1 && pos <= held_len) begin
               r.read_data = held[pos-1];
               r.ok = 1'b1;
            end
         end
         OP_CUR_START: begin
            cursor_pos = 1;
            r.ok = 1'b1;
         end
         OP_CUR_ADV: begin
            if (cursor_pos < DEPTH + 1)
               cursor_pos++;
            r.ok = 1'b1;
         end
         OP_READ_CUR: begin
            if (cursor_pos >= 1 && cursor_pos <= held_len) begin
               r.read_data = held[cursor_pos-1];
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.length   = held_len[CNT_W-1:0];
      r.is_empty = (held_len == 0);
      r.past_end = (cursor_pos > held_len);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      list_result_type fresh;
      if (reset) begin
         held_len   = 0;
         cursor_pos = 0;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("response word with none pending", rsp_tdata[31:0], '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[0] !== want.ok)
                  report_mismatch("ok", rsp_tdata[0], want.ok);
               if (rsp_tdata[32:1] !== want.read_data)
                  report_mismatch("read_data", rsp_tdata[32:1], want.read_data);
               if (rsp_tdata[37:33] !== want.length)
                  report_mismatch("length", rsp_tdata[37:33], want.length);
               if (rsp_tdata[38] !== want.is_empty)
                  report_mismatch("is_empty", rsp_tdata[38], want.is_empty);
               if (rsp_tdata[39] !== want.past_end)
                  report_mismatch("past_end", rsp_tdata[39], want.past_end);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_op_type'(req_tuser), req_tdata[4:0], req_tdata[36:5], fresh);
            expected_words.push_back(fresh);
         end
      end
      pending_count = expected_words.size();
      stored_len    = held_len;
   end

endmodule

// ===== tb/positional_list_store_tb.sv =====
// Testbench top for the positional list store: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps
module positional_list_store_tb;
   import pls_pkg::*;

   localparam logic [2:0] OP_UNUSED      = 3'd7;
   localparam int         RANDOM_WORDS   = 700;
   localparam int         STRETCH        = 40;
   localparam int         HOLD_AT        = 120;
   localparam int         HOLD_CYCLES    = 250;
   localparam int         DRAIN_CYCLES   = 20;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_CURSOR, MIX_ANY} traffic_mix_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   int mismatch_count;
   int pending_count;
   int stored_len;
   bit send_quiet;
   bit take_quiet;

   always #5 clock = ~clock;

   positional_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   list_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .stored_len     (stored_len)
   );

   function automatic int draw_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic send_word(input logic [2:0] op, input logic [4:0] pos,
                            input logic [31:0] w);
      int gap;
      gap = draw_gap(send_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, w, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input traffic_mix_type mix);
      logic [2:0]  op;
      logic [4:0]  pos;
      logic [31:0] w;
      int          roll;
      int          len;
      int          hi;
      len  = stored_len;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:
            op = (roll < 45) ? OP_APPEND : (roll < 80) ? OP_INSERT :
                 (roll < 88) ? OP_READ_POS : (roll < 94) ? OP_CUR_ADV : OP_READ_CUR;
         MIX_DRAIN:
            op = (roll < 55) ? OP_REMOVE : (roll < 75) ? OP_READ_POS :
                 (roll < 85) ? OP_APPEND : (roll < 93) ? OP_READ_CUR : OP_CUR_START;
         MIX_CURSOR:
            op = (roll < 5) ? OP_CUR_START : (roll < 60) ? OP_CUR_ADV :
                 (roll < 90) ? OP_READ_CUR : (roll < 95) ? OP_REMOVE : OP_INSERT;
         default:
            op = 3'($urandom_range(0, 6));
      endcase
      if ($urandom_range(0, 49) == 0)
         op = OP_UNUSED;
      hi = (op == OP_INSERT) ? len + 1 : ((len < 1) ? 1 : len);
      if ($urandom_range(0, 99) < 85)
         pos = 5'($urandom_range(1, hi));
      else
         pos = 5'($urandom_range(0, 31));
      roll = $urandom_range(0, 19);
      w = (roll == 0) ? 32'h0000_0000 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
      send_word(op, pos, w);
   endtask

   // response side: random stalls, one long hold-off to back up the request side
   initial begin
      int gap;
      int rsp_words_taken;
      rsp_words_taken = 0;
      wait (!reset);
      forever begin
         if (rsp_words_taken % STRETCH == 0)
            take_quiet = ($urandom_range(0, 3) == 0);
         gap = (rsp_words_taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(take_quiet);
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_words_taken++;
      end
   end

   initial begin
      traffic_mix_type mix;
      send_quiet = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_word(OP_READ_CUR,  5'd0,  32'h0000_0000);
      send_word(OP_READ_POS,  5'd1,  32'h0000_0000);
      send_word(OP_REMOVE,    5'd1,  32'h0000_0000);
      send_word(OP_INSERT,    5'd0,  32'h1234_5678);
      send_word(OP_INSERT,    5'd2,  32'h1234_5678);
      send_word(OP_INSERT,    5'd1,  32'hFFFF_FFFF);
      send_word(OP_APPEND,    5'd31, 32'h0000_0000);
      send_word(OP_INSERT,    5'd3,  32'hA5A5_A5A5);
      send_word(OP_INSERT,    5'd1,  32'h5A5A_5A5A);
      send_word(OP_READ_POS,  5'd0,  32'h0000_0000);
      send_word(OP_READ_POS,  5'd4,  32'h0000_0000);
      send_word(OP_READ_POS,  5'd5,  32'h0000_0000);
      send_word(OP_READ_POS,  5'd31, 32'hFFFF_FFFF);
      send_word(OP_READ_CUR,  5'd0,  32'h0000_0000);
      send_word(OP_CUR_START, 5'd0,  32'h0000_0000);
      send_word(OP_READ_CUR,  5'd0,  32'h0000_0000);
      send_word(OP_CUR_ADV,   5'd0,  32'h0000_0000);
      send_word(OP_READ_CUR,  5'd0,  32'h0000_0000);
      send_word(OP_REMOVE,    5'd1,  32'h0000_0000);
      send_word(OP_REMOVE,    5'd3,  32'h0000_0000);
      send_word(OP_REMOVE,    5'd3,  32'h0000_0000);
      send_word(OP_REMOVE,    5'd16, 32'h0000_0000);
      send_word(OP_UNUSED,    5'd31, 32'hFFFF_FFFF);
      send_word(OP_CUR_ADV,   5'd17, 32'h0000_0000);
      send_word(OP_READ_CUR,  5'd0,  32'h0000_0000);

      mix = MIX_FILL;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % STRETCH == 0) begin
            mix        = traffic_mix_type'($urandom_range(0, 3));
            send_quiet = ($urandom_range(0, 3) == 0);
         end
         send_random(mix);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("positional_list_store regression: pass");
      else
         $display("positional_list_store regression: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("positional_list_store regression: fail");
      $finish;
   end

endmodule
